[hw/rtl/jsu_pkg.sv]
package jsu_pkg;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_BODY,
        PH_ESC,
        PH_QUAD,
        PH_WANT_BS,
        PH_WANT_U
    } t_phase;

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_DONE = 2'd1,
        KIND_ERR  = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        ERR_NONE         = 4'd0,
        ERR_NO_QUOTE     = 4'd1,
        ERR_CONTROL      = 4'd2,
        ERR_CUT_ESCAPE   = 4'd3,
        ERR_BAD_ESCAPE   = 4'd4,
        ERR_CUT_QUAD     = 4'd5,
        ERR_BAD_HEX      = 4'd6,
        ERR_LONE_HIGH    = 4'd7,
        ERR_BAD_LOW      = 4'd8,
        ERR_STRAY_LOW    = 4'd9,
        ERR_TOO_LONG     = 4'd10,
        ERR_UNTERMINATED = 4'd11
    } t_err;

    typedef logic [3:0][7:0] t_bytes;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       first;
        logic       end_of_input;
    } t_in_word;

    typedef struct packed {
        t_kind      out_kind;
        logic [7:0] out_byte;
        t_err       error_code;
        logic       last;
    } t_out_word;

    typedef struct packed {
        logic [1:0] nm1;
        t_kind      kind;
        t_err       err;
        t_bytes     bytes;
    } t_group;

    typedef struct packed {
        logic [2:0] cnt;
        t_bytes     bytes;
    } t_utf8;

    localparam logic [19:0] MAX_BYTES_RESET = 20'd65535;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    localparam logic [7:0] CTL_BS = 8'h08;
    localparam logic [7:0] CTL_FF = 8'h0C;
    localparam logic [7:0] CTL_LF = 8'h0A;
    localparam logic [7:0] CTL_CR = 8'h0D;
    localparam logic [7:0] CTL_HT = 8'h09;

    localparam logic [15:0] SURR_HI_MIN = 16'hD800;
    localparam logic [15:0] SURR_HI_MAX = 16'hDBFF;
    localparam logic [15:0] SURR_LO_MIN = 16'hDC00;
    localparam logic [15:0] SURR_LO_MAX = 16'hDFFF;
    localparam logic [10:0] SUPP_HI_BIAS = 11'h040;

    localparam logic [7:0] UTF_LEAD2 = 8'hC0;
    localparam logic [7:0] UTF_LEAD3 = 8'hE0;
    localparam logic [7:0] UTF_LEAD4 = 8'hF0;
    localparam logic [7:0] UTF_CONT  = 8'h80;

    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    function automatic t_utf8 utf8_encode(input logic [20:0] cp);
        t_utf8 r;
        r = '0;
        if (cp <= 21'h7F) begin
            r.cnt      = 3'd1;
            r.bytes[0] = cp[7:0];
        end else if (cp <= 21'h7FF) begin
            r.cnt      = 3'd2;
            r.bytes[0] = UTF_LEAD2 | {3'b0, cp[10:6]};
            r.bytes[1] = UTF_CONT | {2'b0, cp[5:0]};
        end else if (cp <= 21'hFFFF) begin
            r.cnt      = 3'd3;
            r.bytes[0] = UTF_LEAD3 | {4'b0, cp[15:12]};
            r.bytes[1] = UTF_CONT | {2'b0, cp[11:6]};
            r.bytes[2] = UTF_CONT | {2'b0, cp[5:0]};
        end else begin
            r.cnt      = 3'd4;
            r.bytes[0] = UTF_LEAD4 | {5'b0, cp[20:18]};
            r.bytes[1] = UTF_CONT | {2'b0, cp[17:12]};
            r.bytes[2] = UTF_CONT | {2'b0, cp[11:6]};
            r.bytes[3] = UTF_CONT | {2'b0, cp[5:0]};
        end
        return r;
    endfunction

endpackage

[hw/rtl/jsu_front.sv]
module jsu_front
    import jsu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  t_in_word    i_word,
    input  logic        i_cfg_wr,
    input  logic [19:0] i_cfg_data,
    output logic        o_push,
    output t_group      o_group
);

    t_phase      r_phase, n_phase;
    logic [15:0] r_hex_accum, n_hex_accum;
    logic [1:0]  r_hex_count, n_hex_count;
    logic        r_hex_bad, n_hex_bad;
    logic [9:0]  r_high_bits, n_high_bits;
    logic        r_in_low_quad, n_in_low_quad;
    logic [19:0] r_bytes_out, n_bytes_out;
    logic [19:0] r_max;

    logic        emit_en;
    t_utf8       emit;
    logic        fail_en;
    t_err        fail_code;
    logic        done_en;
    logic [4:0]  hex;
    logic [15:0] quad;
    logic [7:0]  c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_hex_accum   <= '0;
            r_hex_count   <= '0;
            r_hex_bad     <= 1'b0;
            r_high_bits   <= '0;
            r_in_low_quad <= 1'b0;
            r_bytes_out   <= '0;
            r_max         <= MAX_BYTES_RESET;
        end else begin
            r_phase       <= n_phase;
            r_hex_accum   <= n_hex_accum;
            r_hex_count   <= n_hex_count;
            r_hex_bad     <= n_hex_bad;
            r_high_bits   <= n_high_bits;
            r_in_low_quad <= n_in_low_quad;
            r_bytes_out   <= n_bytes_out;
            if (i_cfg_wr) begin
                r_max <= i_cfg_data;
            end
        end
    end

    always_comb begin
        n_phase       = r_phase;
        n_hex_accum   = r_hex_accum;
        n_hex_count   = r_hex_count;
        n_hex_bad     = r_hex_bad;
        n_high_bits   = r_high_bits;
        n_in_low_quad = r_in_low_quad;
        n_bytes_out   = r_bytes_out;
        emit_en       = 1'b0;
        emit          = '0;
        fail_en       = 1'b0;
        fail_code     = ERR_NONE;
        done_en       = 1'b0;
        c             = i_word.in_byte;
        hex           = hex_decode(c);
        quad          = {r_hex_accum[11:0], hex[3:0]};
        o_push        = 1'b0;
        o_group       = '0;

        if (i_accept) begin
            if (i_word.first) begin
                n_phase = PH_IDLE;
                if (i_word.end_of_input || c != CH_QUOTE) begin
                    fail_en   = 1'b1;
                    fail_code = ERR_NO_QUOTE;
                end else begin
                    n_phase       = PH_BODY;
                    n_bytes_out   = '0;
                    n_hex_accum   = '0;
                    n_hex_count   = '0;
                    n_hex_bad     = 1'b0;
                    n_high_bits   = '0;
                    n_in_low_quad = 1'b0;
                end
            end else begin
                case (r_phase)
                    PH_BODY: begin
                        if (i_word.end_of_input) begin
                            fail_en   = 1'b1;
                            fail_code = ERR_UNTERMINATED;
                        end else if (c == CH_QUOTE) begin
                            done_en = 1'b1;
                            n_phase = PH_IDLE;
                        end else if (c < CH_SPACE) begin
                            fail_en   = 1'b1;
                            fail_code = ERR_CONTROL;
                        end else if (c == CH_BSLASH) begin
                            n_phase = PH_ESC;
                        end else begin
                            emit_en        = 1'b1;
                            emit.cnt       = 3'd1;
                            emit.bytes[0]  = c;
                        end
                    end
                    PH_ESC: begin
                        if (i_word.end_of_input) begin
                            fail_en   = 1'b1;
                            fail_code = ERR_CUT_ESCAPE;
                        end else begin
                            n_phase  = PH_BODY;
                            emit_en  = 1'b1;
                            emit.cnt = 3'd1;
                            case (c)
                                CH_QUOTE, CH_BSLASH, CH_SLASH: emit.bytes[0] = c;
                                CH_B: emit.bytes[0] = CTL_BS;
                                CH_F: emit.bytes[0] = CTL_FF;
                                CH_N: emit.bytes[0] = CTL_LF;
                                CH_R: emit.bytes[0] = CTL_CR;
                                CH_T: emit.bytes[0] = CTL_HT;
                                CH_U: begin
                                    emit_en       = 1'b0;
                                    n_phase       = PH_QUAD;
                                    n_hex_accum   = '0;
                                    n_hex_count   = '0;
                                    n_hex_bad     = 1'b0;
                                    n_in_low_quad = 1'b0;
                                end
                                default: begin
                                    emit_en   = 1'b0;
                                    fail_en   = 1'b1;
                                    fail_code = ERR_BAD_ESCAPE;
                                end
                            endcase
                        end
                    end
                    PH_QUAD: begin
                        if (i_word.end_of_input) begin
                            fail_en   = 1'b1;
                            fail_code = ERR_CUT_QUAD;
                        end else begin
                            n_hex_accum = quad;
                            n_hex_bad   = r_hex_bad | ~hex[4];
                            if (r_hex_count == 2'd3) begin
                                n_hex_count = '0;
                                if (n_hex_bad) begin
                                    fail_en   = 1'b1;
                                    fail_code = ERR_BAD_HEX;
                                end else if (r_in_low_quad) begin
                                    if (quad < SURR_LO_MIN || quad > SURR_LO_MAX) begin
                                        fail_en   = 1'b1;
                                        fail_code = ERR_BAD_LOW;
                                    end else begin
                                        n_phase = PH_BODY;
                                        emit_en = 1'b1;
                                        emit    = utf8_encode(
                                            {11'(r_high_bits) + SUPP_HI_BIAS, quad[9:0]});
                                    end
                                end else if (quad >= SURR_HI_MIN && quad <= SURR_HI_MAX) begin
                                    n_high_bits = quad[9:0];
                                    n_phase     = PH_WANT_BS;
                                end else if (quad >= SURR_LO_MIN && quad <= SURR_LO_MAX) begin
                                    fail_en   = 1'b1;
                                    fail_code = ERR_STRAY_LOW;
                                end else begin
                                    n_phase = PH_BODY;
                                    emit_en = 1'b1;
                                    emit    = utf8_encode({5'b0, quad});
                                end
                            end else begin
                                n_hex_count = r_hex_count + 2'd1;
                            end
                        end
                    end
                    PH_WANT_BS: begin
                        if (i_word.end_of_input || c != CH_BSLASH) begin
                            fail_en   = 1'b1;
                            fail_code = ERR_LONE_HIGH;
                        end else begin
                            n_phase = PH_WANT_U;
                        end
                    end
                    PH_WANT_U: begin
                        if (i_word.end_of_input || c != CH_U) begin
                            fail_en   = 1'b1;
                            fail_code = ERR_LONE_HIGH;
                        end else begin
                            n_phase       = PH_QUAD;
                            n_hex_accum   = '0;
                            n_hex_count   = '0;
                            n_hex_bad     = 1'b0;
                            n_in_low_quad = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            if (emit_en) begin
                if ({1'b0, r_bytes_out} + 21'(emit.cnt) > {1'b0, r_max}) begin
                    fail_en   = 1'b1;
                    fail_code = ERR_TOO_LONG;
                end else begin
                    o_push        = 1'b1;
                    o_group.kind  = KIND_BYTE;
                    o_group.nm1   = 2'(emit.cnt - 3'd1);
                    o_group.bytes = emit.bytes;
                    n_bytes_out   = r_bytes_out + 20'(emit.cnt);
                end
            end
            if (done_en) begin
                o_push       = 1'b1;
                o_group.kind = KIND_DONE;
            end
            if (fail_en) begin
                o_push       = 1'b1;
                o_group      = '0;
                o_group.kind = KIND_ERR;
                o_group.err  = fail_code;
                n_phase      = PH_IDLE;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_err_group_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && o_group.kind == KIND_ERR |-> o_group.nm1 == 2'd0 && o_group.err != ERR_NONE)
        else $error("error group is not a single coded result");
    a_push_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> i_accept)
        else $error("group pushed without an accepted word");
    a_idle_after_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && o_group.kind != KIND_BYTE |=> r_phase == PH_IDLE)
        else $error("decoder not idle after closing quote or error");
`endif

endmodule

[hw/rtl/jsu_queue.sv]
module jsu_queue
    import jsu_pkg::*;
#(
    parameter int unsigned DEPTH = 4
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_group i_data,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_nonempty,
    output t_group o_head
);

    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_group          r_slot [DEPTH];
    logic [PW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            do_push, do_pop;

    assign o_full     = (r_count == CW'(DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_head     = r_slot[r_rd_ptr];
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && o_nonempty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_nonempty |-> !i_pop)
        else $error("pop from empty queue");
`endif

endmodule

[hw/rtl/jsu_back.sv]
module jsu_back
    import jsu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_nonempty,
    input  t_group    i_head,
    output logic      o_pop,
    input  logic      i_stall,
    output logic      o_valid,
    output t_out_word o_word
);

    logic      r_valid;
    t_out_word r_word, n_word;
    logic [1:0] r_idx;
    logic      load;
    logic      at_end;

    assign load   = !r_valid || !i_stall;
    assign at_end = (r_idx == i_head.nm1);
    assign o_pop  = load && i_nonempty && at_end;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_comb begin
        n_word            = '0;
        n_word.out_kind   = i_head.kind;
        n_word.out_byte   = (i_head.kind == KIND_BYTE) ? i_head.bytes[r_idx] : 8'd0;
        n_word.error_code = i_head.err;
        n_word.last       = at_end;
    end

    always_ff @(posedge i_clk) begin
        if (load && i_nonempty) begin
            r_word <= n_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_valid <= i_nonempty;
            if (i_nonempty) begin
                r_idx <= at_end ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_single_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_word.out_kind != KIND_BYTE |-> r_word.last)
        else $error("finish or error result not marked last");
    a_idx_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_nonempty |-> r_idx <= i_head.nm1)
        else $error("byte index beyond group");
`endif

endmodule

[hw/rtl/json_string_unescaper_top.sv]
// JSON string unescaper.
// Input channel: one word per byte of text (i_in_word) with i_in_valid;
// the block drives o_in_stall. A word with first set must carry the
// opening quote; end_of_input marks the end of the text.
// Output channel: o_out_valid with o_out_word (kind, byte, error code,
// last); the receiver drives i_out_stall. A word moves at an edge where
// valid is high and stall is low.
// Config: i_cfg_valid/o_cfg_ready write the string length limit (reset 65535);
// write it only while the block is idle.
// Throughput: one input byte per cycle while results flow. A \u escape
// may give up to four output words, one per unstalled cycle, as input continues
// into a QUEUE_DEPTH-entry group queue; o_in_stall rises when it fills.
// An accepted byte's group is written into the queue, then its first result is loaded into the output register.
// Stalling the output holds the output register and then fills the queue.
// Reset (synchronous, active low) empties the queue and output register
// and leaves the decoder idle, waiting for a word with first set.
module json_string_unescaper_top
    import jsu_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_word    i_in_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_word   o_out_word,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [19:0] i_cfg_data
);

    logic   accept;
    logic   push;
    t_group push_group;
    logic   q_full;
    logic   q_nonempty;
    t_group q_head;
    logic   pop;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = q_full;
    assign accept      = i_in_valid && !q_full;

    jsu_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_word     (i_in_word),
        .i_cfg_wr   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_push     (push),
        .o_group    (push_group)
    );

    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_data     (push_group),
        .i_pop      (pop),
        .o_full     (q_full),
        .o_nonempty (q_nonempty),
        .o_head     (q_head)
    );

    jsu_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_nonempty (q_nonempty),
        .i_head     (q_head),
        .o_pop      (pop),
        .i_stall    (i_out_stall),
        .o_valid    (o_out_valid),
        .o_word     (o_out_word)
    );

endmodule

[dv/jsu_decode_checker.sv]
module jsu_decode_checker
    import jsu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  t_in_word    i_in_word,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_out_word   i_out_word,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [19:0] i_cfg_data,
    output int          o_pending,
    output int          o_mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    t_phase      phase;
    logic [15:0] quad_val;
    logic [1:0]  quad_cnt;
    logic        quad_bad;
    logic [9:0]  high_half;
    logic        low_pending;
    logic [19:0] decoded_cnt;
    logic [19:0] max_len;
    t_out_word   decoded_q[$];
    t_out_word   step_q[$];
    int          mismatches = 0;

    assign o_mismatches = mismatches;

    function automatic void put_word(input t_kind kind, input logic [7:0] b, input t_err code);
        t_out_word w;
        w = '{out_kind: kind, out_byte: b, error_code: code, last: 1'b0};
        step_q.insert(step_q.size(), w);
    endfunction

    function automatic void abort(input t_err code);
        put_word(KIND_ERR, 8'h00, code);
        phase = PH_IDLE;
    endfunction

    // bytes leave in order from grp[7:0] upward, all of them or none
    function automatic void emit_group(input logic [31:0] grp, input int n);
        int i;
        if ({1'b0, decoded_cnt} + 21'(n) > {1'b0, max_len}) begin
            abort(ERR_TOO_LONG);
        end else begin
            for (i = 0; i < n; i++) begin
                put_word(KIND_BYTE, grp[8*i +: 8], ERR_NONE);
            end
            decoded_cnt = decoded_cnt + 20'(n);
        end
    endfunction

    function automatic void emit_code_point(input logic [20:0] cp);
        logic [31:0] g;
        g = '0;
        if (cp <= 21'h7F) begin
            g[7:0] = cp[7:0];
            emit_group(g, 1);
        end else if (cp <= 21'h7FF) begin
            g[7:0]   = {3'b110, cp[10:6]};
            g[15:8]  = {2'b10, cp[5:0]};
            emit_group(g, 2);
        end else if (cp <= 21'hFFFF) begin
            g[7:0]   = {4'b1110, cp[15:12]};
            g[15:8]  = {2'b10, cp[11:6]};
            g[23:16] = {2'b10, cp[5:0]};
            emit_group(g, 3);
        end else begin
            g[7:0]   = {5'b11110, cp[20:18]};
            g[15:8]  = {2'b10, cp[17:12]};
            g[23:16] = {2'b10, cp[11:6]};
            g[31:24] = {2'b10, cp[5:0]};
            emit_group(g, 4);
        end
    endfunction

    function automatic bit nibble_of(input logic [7:0] c, output logic [3:0] v);
        if (c inside {[8'h30:8'h39]}) begin
            v = c[3:0];
            return 1'b1;
        end
        if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            v = c[3:0] + 4'd9;
            return 1'b1;
        end
        v = 4'd0;
        return 1'b0;
    endfunction

    function automatic void close_quad();
        if (quad_bad) begin
            abort(ERR_BAD_HEX);
        end else if (low_pending) begin
            if (quad_val < SURR_LO_MIN || quad_val > SURR_LO_MAX) begin
                abort(ERR_BAD_LOW);
            end else begin
                phase = PH_BODY;
                emit_code_point(21'h10000 + {1'b0, high_half, quad_val[9:0]});
            end
        end else if (quad_val >= SURR_HI_MIN && quad_val <= SURR_HI_MAX) begin
            high_half = quad_val[9:0];
            phase = PH_WANT_BS;
        end else if (quad_val >= SURR_LO_MIN && quad_val <= SURR_LO_MAX) begin
            abort(ERR_STRAY_LOW);
        end else begin
            phase = PH_BODY;
            emit_code_point({5'b0, quad_val});
        end
    endfunction

    function automatic void start_quad(input logic low);
        phase = PH_QUAD;
        quad_val = '0;
        quad_cnt = '0;
        quad_bad = 1'b0;
        low_pending = low;
    endfunction

    function automatic void decode_word(input t_in_word w);
        logic [7:0] c;
        logic [7:0] esc;
        logic [3:0] nib;
        logic       esc_ok;
        c = w.in_byte;
        step_q.delete();
        if (w.first) begin
            phase = PH_IDLE;
            if (w.end_of_input || c != CH_QUOTE) begin
                abort(ERR_NO_QUOTE);
            end else begin
                start_quad(1'b0);
                phase = PH_BODY;
                decoded_cnt = '0;
                high_half = '0;
            end
        end else begin
            case (phase)
                PH_BODY: begin
                    if (w.end_of_input) begin
                        abort(ERR_UNTERMINATED);
                    end else if (c == CH_QUOTE) begin
                        put_word(KIND_DONE, 8'h00, ERR_NONE);
                        phase = PH_IDLE;
                    end else if (c < CH_SPACE) begin
                        abort(ERR_CONTROL);
                    end else if (c == CH_BSLASH) begin
                        phase = PH_ESC;
                    end else begin
                        emit_group({24'b0, c}, 1);
                    end
                end
                PH_ESC: begin
                    if (w.end_of_input) begin
                        abort(ERR_CUT_ESCAPE);
                    end else begin
                        esc_ok = 1'b1;
                        esc = c;
                        case (c)
                            CH_QUOTE, CH_BSLASH, CH_SLASH, CH_U: esc = c;
                            CH_B: esc = CTL_BS;
                            CH_F: esc = CTL_FF;
                            CH_N: esc = CTL_LF;
                            CH_R: esc = CTL_CR;
                            CH_T: esc = CTL_HT;
                            default: esc_ok = 1'b0;
                        endcase
                        if (c == CH_U) begin
                            start_quad(1'b0);
                        end else if (!esc_ok) begin
                            abort(ERR_BAD_ESCAPE);
                        end else begin
                            phase = PH_BODY;
                            emit_group({24'b0, esc}, 1);
                        end
                    end
                end
                PH_QUAD: begin
                    if (w.end_of_input) begin
                        abort(ERR_CUT_QUAD);
                    end else begin
                        if (!nibble_of(c, nib)) begin
                            quad_bad = 1'b1;
                        end
                        quad_val = {quad_val[11:0], nib};
                        if (quad_cnt == 2'd3) begin
                            quad_cnt = 2'd0;
                            close_quad();
                        end else begin
                            quad_cnt = quad_cnt + 2'd1;
                        end
                    end
                end
                PH_WANT_BS: begin
                    if (w.end_of_input || c != CH_BSLASH) begin
                        abort(ERR_LONE_HIGH);
                    end else begin
                        phase = PH_WANT_U;
                    end
                end
                PH_WANT_U: begin
                    if (w.end_of_input || c != CH_U) begin
                        abort(ERR_LONE_HIGH);
                    end else begin
                        start_quad(1'b1);
                    end
                end
                default: ;
            endcase
        end
        if (step_q.size() > 0) begin
            step_q[step_q.size() - 1].last = 1'b1;
        end
        foreach (step_q[k]) begin
            decoded_q.insert(decoded_q.size(), step_q[k]);
        end
    endfunction

    task automatic report_mismatch(input string what, input t_out_word got, input t_out_word want);
        if (mismatches < 100) begin
            $display("%0t: %s: got kind %0d byte %02h code %0d last %0d, want %0d %02h %0d %0d",
                     $time, what, got.out_kind, got.out_byte, got.error_code, got.last,
                     want.out_kind, want.out_byte, want.error_code, want.last);
        end
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            phase       = PH_IDLE;
            quad_val    = '0;
            quad_cnt    = '0;
            quad_bad    = 1'b0;
            high_half   = '0;
            low_pending = 1'b0;
            decoded_cnt = '0;
            max_len     = MAX_BYTES_RESET;
            decoded_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                max_len = i_cfg_data;
            end
            if (i_out_valid && !i_out_stall) begin
                if (decoded_q.size() == 0) begin
                    report_mismatch("word with nothing expected", i_out_word, '0);
                end else begin
                    want = decoded_q.pop_front();
                    if (i_out_word.out_kind !== want.out_kind
                        || i_out_word.out_byte !== want.out_byte
                        || i_out_word.error_code !== want.error_code
                        || i_out_word.last !== want.last) begin
                        report_mismatch("word mismatch", i_out_word, want);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                decode_word(i_in_word);
            end
        end
        o_pending <= decoded_q.size();
    end

endmodule

[dv/tb_json_string_unescaper_top.sv]
module tb_json_string_unescaper_top;
    timeunit 1ns;
    timeprecision 1ps;
    import jsu_pkg::*;

    localparam int WATCHDOG_CYCLES = 2000;
    localparam int HOLD_CYCLES     = 64;
    localparam int DRAIN_CYCLES    = 8;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    t_in_word    in_word   = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out_word   out_word;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [19:0] cfg_data  = '0;

    int          pending;
    int          mismatches;
    int          items_sent   = 0;
    int          stuck_cycles = 0;
    bit          idling_on    = 1'b1;
    bit          pressure_on  = 1'b0;

    json_string_unescaper_top u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    jsu_decode_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_word   (out_word),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_mismatches (mismatches)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles == WATCHDOG_CYCLES) begin
            $display("json_string_unescaper_top verification failed");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin : sink
        bit held;
        held = 1'b0;
        forever begin
            @(posedge clk);
            if (pressure_on && !held) begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end else if (idling_on && $urandom_range(0, 4) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic push_word(input logic [7:0] b, input bit first, input bit eoi,
                             input bit counted);
        t_in_word w;
        if (idling_on && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        w.in_byte      = b;
        w.first        = first;
        w.end_of_input = eoi;
        in_word  <= w;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        if (counted) begin
            items_sent++;
        end
    endtask

    task automatic send_text(input logic [7:0] b);
        push_word(b, 1'b0, 1'b0, 1'b1);
    endtask

    task automatic open_string();
        push_word(CH_QUOTE, 1'b1, 1'b0, 1'b1);
    endtask

    task automatic send_end();
        push_word(8'($urandom), 1'b0, 1'b1, 1'b1);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) begin
            return 8'h30 + 8'(n);
        end
        return (($urandom_range(0, 1) != 0) ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
    endfunction

    function automatic logic [7:0] bad_hex_char();
        case ($urandom_range(0, 7))
            0: return 8'h2F;
            1: return 8'h3A;
            2: return 8'h40;
            3: return 8'h47;
            4: return 8'h60;
            5: return 8'h67;
            6: return 8'($urandom_range(8'h80, 8'hFF));
            default: return 8'($urandom_range(8'h00, 8'h1F));
        endcase
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(8'h20, 8'hFF)); while (b == CH_QUOTE || b == CH_BSLASH);
        return b;
    endfunction

    function automatic logic [7:0] escape_letter();
        case ($urandom_range(0, 7))
            0: return CH_QUOTE;
            1: return CH_BSLASH;
            2: return CH_SLASH;
            3: return CH_B;
            4: return CH_F;
            5: return CH_N;
            6: return CH_R;
            default: return CH_T;
        endcase
    endfunction

    function automatic logic [15:0] bmp_value();
        case ($urandom_range(0, 4))
            0: return 16'($urandom_range(0, 16'h7F));
            1: return 16'($urandom_range(16'h80, 16'h7FF));
            2: return 16'($urandom_range(16'h800, 16'hD7FF));
            3: return 16'($urandom_range(16'hE000, 16'hFFFF));
            default: return ($urandom_range(0, 1) != 0) ? 16'h0000 : 16'hFFFF;
        endcase
    endfunction

    function automatic logic [15:0] high_value();
        if ($urandom_range(0, 7) == 0) begin
            return SURR_HI_MIN;
        end
        return 16'($urandom_range(SURR_HI_MIN, SURR_HI_MAX));
    endfunction

    function automatic logic [15:0] low_value();
        if ($urandom_range(0, 7) == 0) begin
            return SURR_LO_MIN;
        end
        return 16'($urandom_range(SURR_LO_MIN, SURR_LO_MAX));
    endfunction

    task automatic send_quad(input logic [15:0] v, input int bad_pos);
        int i;
        send_text(CH_BSLASH);
        send_text(CH_U);
        for (i = 0; i < 4; i++) begin
            send_text((i == bad_pos) ? bad_hex_char() : hex_char(v[4*(3-i) +: 4]));
        end
    endtask

    task automatic broken_tail();
        logic [7:0]  b;
        logic [15:0] v;
        case ($urandom_range(0, 9))
            0: send_text(8'($urandom_range(0, 8'h1F)));
            1: begin
                do b = 8'($urandom);
                while (b inside {CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R,
                                 CH_T, CH_U});
                send_text(CH_BSLASH);
                send_text(b);
            end
            2: send_quad(bmp_value(), $urandom_range(0, 3));
            3: begin
                send_quad(high_value(), -1);
                send_text(plain_byte());
            end
            4: begin
                do b = plain_byte(); while (b == CH_U);
                send_quad(high_value(), -1);
                send_text(CH_BSLASH);
                send_text(b);
            end
            5: begin
                do v = 16'($urandom); while (v >= SURR_LO_MIN && v <= SURR_LO_MAX);
                send_quad(high_value(), -1);
                send_quad(v, -1);
            end
            6: send_quad(low_value(), -1);
            7: begin
                // cut the input short at each point of an escape
                case ($urandom_range(0, 4))
                    0: ;
                    1: send_text(CH_BSLASH);
                    2: begin
                        send_text(CH_BSLASH);
                        send_text(CH_U);
                        repeat ($urandom_range(0, 3)) send_text(hex_char(4'($urandom)));
                    end
                    3: send_quad(high_value(), -1);
                    default: begin
                        send_quad(high_value(), -1);
                        send_text(CH_BSLASH);
                    end
                endcase
                send_end();
            end
            8: push_word(($urandom_range(0, 1) != 0) ? CH_QUOTE : 8'($urandom),
                         1'b1, 1'b0, 1'b1);
            default: begin
                send_text(CH_QUOTE);
                repeat ($urandom_range(1, 2)) push_word(8'($urandom), 1'b0, 1'($urandom), 1'b0);
            end
        endcase
    endtask

    task automatic random_string();
        int pick;
        open_string();
        repeat ($urandom_range(0, 6)) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                send_text(plain_byte());
            end else if (pick < 55) begin
                send_text(CH_BSLASH);
                send_text(escape_letter());
            end else if (pick < 75) begin
                send_quad(bmp_value(), -1);
            end else if (pick < 90) begin
                send_quad(high_value(), -1);
                send_quad(low_value(), -1);
            end else begin
                broken_tail();
                return;
            end
        end
        pick = $urandom_range(0, 9);
        if (pick < 8) begin
            send_text(CH_QUOTE);
        end else if (pick == 8) begin
            send_end();
        end else begin
            broken_tail();
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_max_len(input logic [19:0] v);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_word(8'h00, 1'b1, 1'b0, 1'b1);
        push_word(CH_QUOTE, 1'b1, 1'b1, 1'b1);
        open_string();
        send_text(8'hFF);
        send_text(CH_SPACE);
        send_text(8'h1F);
        open_string();
        send_text(CH_BSLASH);
        send_text(CH_T);
        send_quad(SURR_HI_MAX, -1);
        send_quad(SURR_LO_MAX, -1);
        send_text(CH_QUOTE);
        open_string();
        send_text(CH_BSLASH);
        send_end();
        open_string();
        send_text(8'h61);
        settle();

        // drop the limit under the count of a string still open
        set_max_len(20'd0);
        send_text(8'h62);
        open_string();
        send_text(CH_QUOTE);
        open_string();
        send_quad(16'h0041, -1);
        settle();

        set_max_len(20'hFFFFF);
        while (items_sent < 120) random_string();
        pressure_on <= 1'b1;
        while (items_sent < 200) random_string();
        settle();

        set_max_len(20'($urandom_range(1, 8)));
        while (items_sent < 320) random_string();
        settle();

        idling_on <= 1'b0;
        set_max_len(20'($urandom_range(9, 40)));
        while (items_sent < 420) random_string();
        settle();

        if (mismatches == 0) begin
            $display("json_string_unescaper_top verification clean");
        end else begin
            $display("json_string_unescaper_top verification failed");
        end
        $finish;
    end

endmodule
